// File: rtl/core/mtem_pkg.sv
// Shared types and constants of the multi-timer expiry manager.
package mtem_pkg;

  localparam int unsigned TIMER_COUNT_DEF = 32;
  localparam int unsigned TIME_BITS_DEF   = 32;

  localparam int unsigned MODE_W  = 2;
  localparam int unsigned ID_W    = 5;
  localparam int unsigned DUR_W   = 31;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 2'd0,
    MODE_START = 2'd1,
    MODE_STOP  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  // Head of the expiry queue as seen by the output side.
  typedef struct packed {
    logic valid;  // an expired timer waits at the head
    logic last;   // no further expired timer behind the head
  } head_t;

endpackage

// File: rtl/core/mtem_expiry_queue.sv
// Set of timers expired on the current tick, handed out in ascending id order.
module mtem_expiry_queue #(
  parameter int unsigned TIMER_COUNT = mtem_pkg::TIMER_COUNT_DEF,
  parameter int unsigned IDX_W       = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic             set_i,
  input  logic [IDX_W-1:0] set_idx_i,
  input  logic             pop_i,
  output mtem_pkg::head_t  head_o,
  output logic [IDX_W-1:0] head_idx_o
);
  import mtem_pkg::*;

  logic [TIMER_COUNT-1:0] exp_q, exp_d;
  logic [TIMER_COUNT-1:0] low_onehot;
  logic [IDX_W-1:0]       low_idx;

  // Isolate the lowest pending timer.
  assign low_onehot = exp_q & (~exp_q + TIMER_COUNT'(1));

  always_comb begin
    low_idx = '0;
    for (int unsigned i = 0; i < TIMER_COUNT; i++) begin
      if (low_onehot[i]) begin
        low_idx = low_idx | IDX_W'(i);
      end
    end
  end

  assign head_idx_o   = low_idx;
  assign head_o.valid = |exp_q;
  assign head_o.last  = ~|(exp_q & ~low_onehot);

  always_comb begin
    exp_d = exp_q;
    if (clear_i) begin
      exp_d = '0;
    end else begin
      if (pop_i) begin
        exp_d = exp_d & ~low_onehot;
      end
      if (set_i) begin
        exp_d[set_idx_i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= '0;
    end else begin
      exp_q <= exp_d;
    end
  end

endmodule

// File: rtl/core/multi_timer_expiry_manager_top.sv
// Top level of the multi-timer expiry manager: command decode, timeout memory and tick scan.
//
// A bank of TIMER_COUNT one-shot timers against a wrapping TIME_BITS-bit time counter.
// Each request carries a mode in s_axis_tuser: tick, start or stop. A start re-arms the
// addressed timer at now + max(duration, 1), with the duration capped just below half
// the time range; a stop disarms it; ids at or above TIMER_COUNT and the unused mode
// are dropped. Commands produce no result. A tick advances the time by one, then reads
// every timer's timeout from the timeout memory, one entry per cycle, and its first
// result appears once the scan is complete. It then delivers one result per expired
// timer in ascending id order (or a single result with tuser low when none expired),
// one per cycle while m_axis_tready is high; tlast marks the final result of the tick
// and every result carries the running count after all of the tick's expiries. A new
// request is taken only once the previous one is complete. Timeout entries are undefined
// after reset and are only compared for armed timers, so no clearing pass is needed;
// the armed flags reset to zero.
module multi_timer_expiry_manager_top #(
  parameter int unsigned TIMER_COUNT = mtem_pkg::TIMER_COUNT_DEF,
  parameter int unsigned TIME_BITS   = mtem_pkg::TIME_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [4:0] timer_id, [35:5] duration, [39:36] zero
  input  logic [mtem_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [1:0] mode
  input  logic [mtem_pkg::MODE_W-1:0]         s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [4:0] expired_id, [10:5] running_count, [15:11] zero
  output logic [mtem_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // [0] expired_valid
  output logic                                m_axis_tuser,
  output logic                                m_axis_tlast
);
  import mtem_pkg::*;

  localparam int unsigned IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int unsigned CNT_W = $clog2(TIMER_COUNT + 1);
  localparam logic [DUR_W-1:0] MAX_DUR = DUR_W'((64'd1 << (TIME_BITS - 1)) - 64'd1);

  // Request fields.
  mode_e            req_mode;
  logic [ID_W-1:0]  req_id;
  logic [DUR_W-1:0] req_dur;
  logic [IDX_W-1:0] req_idx;
  logic             req_in_range;
  logic [DUR_W-1:0] dur_sat;
  logic             in_acc;
  logic             out_acc;

  assign req_mode     = mode_e'(s_axis_tuser);
  assign req_id       = s_axis_tdata[ID_W-1:0];
  assign req_dur      = s_axis_tdata[ID_W +: DUR_W];
  assign req_idx      = IDX_W'(req_id);
  assign req_in_range = {2'b00, req_id} < 7'(TIMER_COUNT);

  always_comb begin
    dur_sat = (req_dur > MAX_DUR) ? MAX_DUR : req_dur;
    if (dur_sat == '0) begin
      dur_sat = DUR_W'(1);
    end
  end

  // Control state.
  state_e                 state_q, state_d;
  logic [TIME_BITS-1:0]   time_q, time_d;
  logic [TIMER_COUNT-1:0] run_q, run_d;
  logic [COUNT_W-1:0]     total_q, total_d;
  logic [CNT_W-1:0]       scan_q, scan_d;
  logic                   rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]       rd_idx_q, rd_idx_d;

  // Timeout memory, one write and one registered read port.
  logic [TIME_BITS-1:0] mem_q [TIMER_COUNT];
  logic [TIME_BITS-1:0] rd_data_q;
  logic                 mem_we;
  logic [TIME_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [IDX_W-1:0]     mem_raddr;

  // Expiry queue interface.
  logic             q_clear;
  logic             q_set;
  logic             q_pop;
  head_t            head;
  logic [IDX_W-1:0] head_idx;
  logic             hit;
  logic             scan_done;

  assign in_acc    = s_axis_tvalid & s_axis_tready;
  assign out_acc   = m_axis_tvalid & m_axis_tready;
  assign scan_done = (scan_q == CNT_W'(TIMER_COUNT)) && !rd_vld_q;
  assign hit       = rd_vld_q && run_q[rd_idx_q] && (rd_data_q == time_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && req_mode == MODE_TICK) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_acc && (head.last || !head.valid)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath control.
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    time_d        = time_q;
    run_d         = run_q;
    total_d       = total_q;
    scan_d        = scan_q;
    rd_vld_d      = 1'b0;
    rd_idx_d      = rd_idx_q;
    mem_we        = 1'b0;
    mem_wdata     = time_q + TIME_BITS'(dur_sat);
    mem_re        = 1'b0;
    mem_raddr     = scan_q[IDX_W-1:0];
    q_clear       = 1'b0;
    q_set         = 1'b0;
    q_pop         = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_acc) begin
          case (req_mode)
            MODE_TICK: begin
              // Advance time and start the scan from the lowest id.
              time_d  = time_q + TIME_BITS'(1);
              scan_d  = '0;
              q_clear = 1'b1;
            end
            MODE_START: begin
              if (req_in_range) begin
                mem_we           = 1'b1;
                run_d[req_idx]   = 1'b1;
                total_d          = total_q + COUNT_W'(!run_q[req_idx]);
              end
            end
            MODE_STOP: begin
              if (req_in_range) begin
                run_d[req_idx] = 1'b0;
                total_d        = total_q - COUNT_W'(run_q[req_idx]);
              end
            end
            default: begin
              // Unused mode: drop.
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_q != CNT_W'(TIMER_COUNT)) begin
          mem_re   = 1'b1;
          rd_vld_d = 1'b1;
          rd_idx_d = scan_q[IDX_W-1:0];
          scan_d   = scan_q + CNT_W'(1);
        end
        if (hit) begin
          run_d[rd_idx_q] = 1'b0;
          total_d         = total_q - COUNT_W'(1);
          q_set           = 1'b1;
        end
      end
      ST_EMIT: begin
        m_axis_tvalid = 1'b1;
        q_pop         = out_acc && head.valid;
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tuser = head.valid;
  assign m_axis_tlast = head.last || !head.valid;
  assign m_axis_tdata = {(OUT_DATA_W - COUNT_W - ID_W)'(0), total_q,
                         head.valid ? ID_W'(head_idx) : ID_W'(0)};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[req_idx] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      time_q   <= '0;
      run_q    <= '0;
      total_q  <= '0;
      scan_q   <= '0;
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      state_q  <= state_d;
      time_q   <= time_d;
      run_q    <= run_d;
      total_q  <= total_d;
      scan_q   <= scan_d;
      rd_vld_q <= rd_vld_d;
      rd_idx_q <= rd_idx_d;
    end
  end

  mtem_expiry_queue #(
    .TIMER_COUNT (TIMER_COUNT),
    .IDX_W       (IDX_W)
  ) u_expiry_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (q_clear),
    .set_i      (q_set),
    .set_idx_i  (rd_idx_q),
    .pop_i      (q_pop),
    .head_o     (head),
    .head_idx_o (head_idx)
  );

endmodule
